// ===== rtl/kcl_pkg.sv =====
// Shared types and constants for the keypad code lock.
// Used by the decoder, the lock state logic, the top level and the checker.
`timescale 1ns / 1ps

package kcl_pkg;

    localparam int KEY_W  = 5;
    localparam int CHAR_W = 7;
    localparam int ACT_W  = 3;
    localparam int DIG_W  = 4;
    localparam int CNT_W  = 3;
    localparam int PASS_W = 24;

    localparam logic [PASS_W-1:0] PASS_RESET = 24'h123123;

    localparam logic [KEY_W-1:0] KEY_STAR = 5'd13;
    localparam logic [KEY_W-1:0] KEY_HASH = 5'd15;

    // display actions
    localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ECHO     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LEFT     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RIGHT    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MATCHED  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_MISMATCH = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RELOCKED = 3'd6;

    typedef struct packed {
        logic              valid;
        logic              is_digit;
        logic              is_star;
        logic              is_hash;
        logic [DIG_W-1:0]  digit;
        logic [CHAR_W-1:0] ascii;
    } key_info_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CHAR_W-1:0] echo_char;
        logic              motor_on;
        logic [CNT_W-1:0]  digits_entered;
    } result_t;

endpackage

// ===== rtl/kcl_key_decode.sv =====
// Keypad key number decoder: ASCII character, digit value and key class.
// Depends on kcl_pkg.
`timescale 1ns / 1ps

module kcl_key_decode
    import kcl_pkg::*;
(
    input  logic [KEY_W-1:0] key_code,
    output key_info_t        info
);

    always_comb begin
        info          = '0;
        info.valid    = 1'b1;
        info.is_digit = 1'b1;
        case (key_code)
            5'd1:  begin info.digit = 4'd1; info.ascii = 7'd49; end
            5'd2:  begin info.digit = 4'd2; info.ascii = 7'd50; end
            5'd3:  begin info.digit = 4'd3; info.ascii = 7'd51; end
            5'd4:  begin info.is_digit = 1'b0; info.ascii = 7'd65; end
            5'd5:  begin info.digit = 4'd4; info.ascii = 7'd52; end
            5'd6:  begin info.digit = 4'd5; info.ascii = 7'd53; end
            5'd7:  begin info.digit = 4'd6; info.ascii = 7'd54; end
            5'd8:  begin info.is_digit = 1'b0; info.ascii = 7'd66; end
            5'd9:  begin info.digit = 4'd7; info.ascii = 7'd55; end
            5'd10: begin info.digit = 4'd8; info.ascii = 7'd56; end
            5'd11: begin info.digit = 4'd9; info.ascii = 7'd57; end
            5'd12: begin info.is_digit = 1'b0; info.ascii = 7'd67; end
            KEY_STAR: begin
                info.is_digit = 1'b0;
                info.is_star  = 1'b1;
                info.ascii    = 7'd42;
            end
            5'd14: begin info.digit = 4'd0; info.ascii = 7'd48; end
            KEY_HASH: begin
                info.is_digit = 1'b0;
                info.is_hash  = 1'b1;
                info.ascii    = 7'd35;
            end
            5'd16: begin info.is_digit = 1'b0; info.ascii = 7'd68; end
            default: begin
                // key number outside the pad: ignored, no echo
                info = '0;
            end
        endcase
    end

endmodule

// ===== rtl/kcl_lock_core.sv =====
// Lock state: entered digits, entry position and lock flag, with the
// per-key update and code compare. Depends on kcl_pkg.
`timescale 1ns / 1ps

module kcl_lock_core
    import kcl_pkg::*;
#(
    parameter int CODE_LENGTH = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  key_info_t         info,
    input  logic [PASS_W-1:0] password,
    output result_t           result
);

    localparam int POS_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [POS_W:0] LAST_POS = (POS_W + 1)'(CODE_LENGTH);

    logic [DIG_W-1:0] digits_reg  [CODE_LENGTH];
    logic [DIG_W-1:0] digits_next [CODE_LENGTH];
    logic [DIG_W-1:0] pass_nib    [CODE_LENGTH];
    logic [CODE_LENGTH-1:0] nib_eq;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             unlocked_reg, unlocked_next;
    logic [POS_W:0]   pos_inc;
    logic             write_en;
    logic             advance;
    logic [ACT_W-1:0] action;

    // nibble for position i sits at bit 4*(CODE_LENGTH-1-i); above the register reads as 0
    for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_nib
        localparam int SH = 4 * (CODE_LENGTH - 1 - i);
        if (SH + DIG_W <= PASS_W) begin : g_in
            assign pass_nib[i] = password[SH +: DIG_W];
        end else begin : g_out
            assign pass_nib[i] = '0;
        end
        assign nib_eq[i] = (pass_nib[i] == digits_next[i]);
    end

    assign write_en = info.valid && !unlocked_reg && info.is_digit;
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;

    always_comb begin
        for (int i = 0; i < CODE_LENGTH; i++) begin
            digits_next[i] = (write_en && pos_reg == POS_W'(i)) ? info.digit : digits_reg[i];
        end
    end

    always_comb begin
        pos_next      = pos_reg;
        unlocked_next = unlocked_reg;
        action        = ACT_NONE;
        advance       = 1'b0;
        if (info.valid) begin
            if (unlocked_reg) begin
                if (info.is_star) begin
                    unlocked_next = 1'b0;
                    pos_next      = '0;
                    action        = ACT_RELOCKED;
                end
            end else if (info.is_digit) begin
                advance = 1'b1;
                action  = ACT_ECHO;
            end else if (info.is_star) begin
                // backspace saturates at position zero
                if (pos_reg != '0) begin
                    pos_next = pos_reg - 1'b1;
                    action   = ACT_LEFT;
                end
            end else if (info.is_hash) begin
                advance = 1'b1;
                action  = ACT_RIGHT;
            end else begin
                action = ACT_ECHO;
            end
            if (advance) begin
                if (pos_inc >= LAST_POS) begin
                    pos_next = '0;
                    if (&nib_eq) begin
                        unlocked_next = 1'b1;
                        action        = ACT_MATCHED;
                    end else begin
                        action = ACT_MISMATCH;
                    end
                end else begin
                    pos_next = pos_inc[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CODE_LENGTH; i++) begin
                digits_reg[i] <= '0;
            end
            pos_reg      <= '0;
            unlocked_reg <= 1'b0;
        end else if (step) begin
            digits_reg   <= digits_next;
            pos_reg      <= pos_next;
            unlocked_reg <= unlocked_next;
        end
    end

    always_comb begin
        result.action         = action;
        result.echo_char      = info.ascii;
        result.motor_on       = unlocked_next;
        result.digits_entered = CNT_W'({{CNT_W{1'b0}}, pos_next});
    end

endmodule

// ===== rtl/keypad_code_lock.sv =====
// Top level of the keypad code lock: stream ports, input and result registers,
// password register. Depends on kcl_pkg, kcl_key_decode and kcl_lock_core.
`timescale 1ns / 1ps

// Keypad code lock. Each request on s_ carries one 4x4 keypad key number and
// yields exactly one result on m_ (display action, echo character, motor
// state, entry position). The block takes one key per cycle while m_tready is
// high; a key passes through the input register and then the result register,
// with the whole state update and code compare done in the single
// combinational step between them. Both registers advance together:
// a new key is taken in the cycle the previous result leaves, and while m_tready
// stays low the block holds one waiting result and one key, then drops s_tready.
// The unlock code is written over the cfg_ port, which is always ready; write it
// only while no key is in flight. Reset code is 123123.
module keypad_code_lock
    import kcl_pkg::*;
#(
    parameter int CODE_LENGTH = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] key_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] display_action, [9:3] echo_char,
                                   // [10] motor_on, [13:11] digits_entered
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data   // password_digits
);

    logic              in_valid_reg;
    logic [KEY_W-1:0]  in_key_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic [PASS_W-1:0] pass_reg;
    logic              step;
    key_info_t         info;
    result_t           result;

    assign step      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pass_reg      <= PASS_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                pass_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_key_reg <= s_tdata[KEY_W-1:0];
        end
        if (step) begin
            out_reg <= result;
        end
    end

    kcl_key_decode u_decode (
        .key_code (in_key_reg),
        .info     (info)
    );

    kcl_lock_core #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .info     (info),
        .password (pass_reg),
        .result   (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.digits_entered, out_reg.motor_on,
                       out_reg.echo_char, out_reg.action};

endmodule

// ===== rtl/kcl_checker.sv =====
// Port-level checks for the keypad code lock, bound to the top level.
// Depends on kcl_pkg and keypad_code_lock.
`timescale 1ns / 1ps

module kcl_checker
    import kcl_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic [ACT_W-1:0] act;
    logic             motor;
    logic [CNT_W-1:0] cnt;

    assign act   = m_tdata[2:0];
    assign motor = m_tdata[10];
    assign cnt   = m_tdata[13:11];

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_matched: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && act == ACT_MATCHED |-> motor && cnt == '0)
        else $error("match without motor or with nonzero position");

    a_mismatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (act == ACT_MISMATCH || act == ACT_RELOCKED) |-> !motor && cnt == '0)
        else $error("mismatch or relock left motor on or position set");

    // only locked keys echo or move the cursor
    a_locked_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (act == ACT_ECHO || act == ACT_LEFT || act == ACT_RIGHT) |-> !motor)
        else $error("entry action while unlocked");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
